// ===== rtl/core/dhfp_pkg.sv =====
// shared constants and types of the desk height frame parser
package dhfp_pkg;

	localparam int FRAME_SPAN = 16;
	localparam int POS_W = $clog2(FRAME_SPAN);
	localparam int END_W = $clog2(FRAME_SPAN + 1);
	localparam int LEN_W = 9;

	localparam logic [7:0] SYNC_BYTE = 8'hF2;
	localparam logic [7:0] END_BYTE = 8'h7E;
	localparam logic [7:0] HEIGHT_CMD = 8'h01;
	// frame end position is length position plus length plus two
	localparam logic [LEN_W-1:0] LEN_EXTRA = LEN_W'(3 + 2);
	localparam logic [LEN_W-1:0] LAST_POS = LEN_W'(FRAME_SPAN - 1);
	localparam logic [END_W-1:0] END_UNKNOWN = END_W'(FRAME_SPAN);

	typedef enum logic [2:0] {
		KIND_HEIGHT   = 3'd0,
		KIND_OTHER    = 3'd1,
		KIND_SYNC     = 3'd2,
		KIND_LENGTH   = 3'd3,
		KIND_CHECKSUM = 3'd4,
		KIND_END      = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		MOTION_IDLE = 2'd0,
		MOTION_UP   = 2'd1,
		MOTION_DOWN = 2'd2
	} motion_t;

	// outcome of one byte at the framing level
	typedef struct packed {
		logic        good;
		logic        bad;
		kind_t       err_kind;
		logic [7:0]  command;
		logic [15:0] height;
	} frame_evt_t;

	typedef struct packed {
		logic        hit;
		kind_t       kind;
		logic [7:0]  command;
		logic [15:0] height_tenths;
		motion_t     motion;
		logic        motion_changed;
		logic        warning;
	} result_t;

endpackage

// ===== rtl/core/dhfp_rx_if.sv =====
// received byte channel
interface dhfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/dhfp_res_if.sv =====
// result channel
interface dhfp_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  command;
	logic [15:0] height_tenths;
	logic [1:0]  motion;
	logic        motion_changed;
	logic        warning;

	modport source (output valid, output kind, output command, output height_tenths,
		output motion, output motion_changed, output warning, input ready);
	modport sink (input valid, input kind, input command, input height_tenths,
		input motion, input motion_changed, input warning, output ready);
endinterface

// ===== rtl/core/dhfp_frame_check.sv =====
// frame position tracking, sync, length, checksum and end byte checks
module dhfp_frame_check (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data,
	output dhfp_pkg::frame_evt_t evt
);
	import dhfp_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [END_W-1:0] end_q;
	logic [7:0]       sum_q;
	logic [7:0]       cmd_q;
	logic [15:0]      hb_q;

	logic [END_W-1:0] pos_ext;
	logic [LEN_W-1:0] len_end;
	logic [7:0]       sum_add;
	logic [15:0]      hb_next;

	assign pos_ext = END_W'(pos_q);
	assign len_end = LEN_W'(data) + LEN_EXTRA;
	assign sum_add = sum_q + data;

	always_comb begin
		hb_next = hb_q;
		if (pos_q == POS_W'(4)) begin
			hb_next[15:8] = data;
		end else if (pos_q == POS_W'(5)) begin
			hb_next[7:0] = data;
		end
	end

	always_comb begin
		evt = '0;
		evt.err_kind = KIND_SYNC;
		evt.command = cmd_q;
		evt.height = hb_next;
		priority if (pos_q == POS_W'(0) || pos_q == POS_W'(1)) begin
			if (data != SYNC_BYTE) begin
				evt.bad = 1'b1;
				evt.err_kind = KIND_SYNC;
			end
		end else if (pos_q == POS_W'(2)) begin
			evt.bad = 1'b0;
		end else if (pos_q == POS_W'(3)) begin
			if (len_end > LAST_POS) begin
				evt.bad = 1'b1;
				evt.err_kind = KIND_LENGTH;
			end
		end else if (pos_ext + END_W'(1) == end_q) begin
			if (data != sum_q) begin
				evt.bad = 1'b1;
				evt.err_kind = KIND_CHECKSUM;
			end
		end else if (pos_ext == end_q) begin
			if (data != END_BYTE) begin
				evt.bad = 1'b1;
				evt.err_kind = KIND_END;
			end else begin
				evt.good = 1'b1;
			end
		end else begin
			evt.bad = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			end_q <= END_UNKNOWN;
			sum_q <= '0;
			cmd_q <= '0;
			hb_q <= '0;
		end else if (step) begin
			hb_q <= hb_next;
			if (evt.good || evt.bad) begin
				pos_q <= '0;
				end_q <= END_UNKNOWN;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				priority if (pos_q == POS_W'(0) || pos_q == POS_W'(1)) begin
					sum_q <= sum_q;
				end else if (pos_q == POS_W'(2)) begin
					cmd_q <= data;
					sum_q <= data;
				end else if (pos_q == POS_W'(3)) begin
					end_q <= len_end[END_W-1:0];
					sum_q <= sum_add;
				end else if (pos_ext + END_W'(1) == end_q) begin
					sum_q <= sum_q;
				end else begin
					sum_q <= sum_add;
				end
			end
		end
	end

endmodule

// ===== rtl/core/dhfp_motion.sv =====
// height report building, motion tracking and warning status
module dhfp_motion (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  dhfp_pkg::frame_evt_t evt,
	output dhfp_pkg::result_t    rslt
);
	import dhfp_pkg::*;

	logic [15:0] last_height_q;
	logic        known_q;
	motion_t     last_motion_q;
	logic        warning_q;

	logic    is_height;
	motion_t motion_new;

	assign is_height = evt.good && (evt.command == HEIGHT_CMD);

	always_comb begin
		motion_new = MOTION_IDLE;
		if (known_q) begin
			if (evt.height > last_height_q) begin
				motion_new = MOTION_UP;
			end else if (evt.height < last_height_q) begin
				motion_new = MOTION_DOWN;
			end
		end
	end

	always_comb begin
		rslt = '0;
		rslt.kind = KIND_OTHER;
		rslt.motion = MOTION_IDLE;
		rslt.hit = evt.good || evt.bad;
		if (evt.bad) begin
			rslt.kind = evt.err_kind;
			rslt.warning = 1'b1;
		end else if (evt.good) begin
			rslt.command = evt.command;
			if (is_height) begin
				rslt.kind = KIND_HEIGHT;
				rslt.height_tenths = evt.height;
				rslt.motion = motion_new;
				rslt.motion_changed = (motion_new != last_motion_q);
			end
		end else begin
			rslt.warning = warning_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_height_q <= '0;
			known_q <= 1'b0;
			last_motion_q <= MOTION_IDLE;
			warning_q <= 1'b0;
		end else if (step) begin
			if (evt.bad) begin
				warning_q <= 1'b1;
			end else if (evt.good) begin
				warning_q <= 1'b0;
			end
			if (is_height) begin
				last_height_q <= evt.height;
				known_q <= 1'b1;
				last_motion_q <= motion_new;
			end
		end
	end

endmodule

// ===== rtl/core/desk_height_frame_parser.sv =====
// desk height frame parser: byte input register, frame checks, result register
// path: an accepted byte is held in the input register, and its result is then registered in the result register
// throughput: one byte per cycle while no finished result waits unread; the input register
// can still take one byte while a finished result waits, after which the input stalls
// reset: asynchronous, hunt restarts at position zero, no height known, motion idle,
// warning clear, no byte or result held
module desk_height_frame_parser (
	input  logic clk,
	input  logic arst_n,
	dhfp_rx_if.sink rx,
	dhfp_res_if.source res
);
	import dhfp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       res_valid_q;
	result_t    res_q;

	frame_evt_t evt;
	result_t    rslt;

	assign advance = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	dhfp_frame_check u_frame_check (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.data   (byte_s1),
		.evt    (evt)
	);

	dhfp_motion u_motion (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.evt    (evt),
		.rslt   (rslt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (advance && rslt.hit) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && rslt.hit) begin
			res_q <= rslt;
		end
	end

	assign res.valid = res_valid_q;
	assign res.kind = res_q.kind;
	assign res.command = res_q.command;
	assign res.height_tenths = res_q.height_tenths;
	assign res.motion = res_q.motion;
	assign res.motion_changed = res_q.motion_changed;
	assign res.warning = res_q.warning;

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench of the desk height frame parser
`timescale 1ns / 100ps

module testbench;
	import dhfp_pkg::*;

	localparam int MAX_LEN = FRAME_SPAN - 1 - int'(LEN_EXTRA);
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int PRINT_CAP = 40;

	typedef enum int {
		FAULT_NONE,
		FAULT_SYNC_FIRST,
		FAULT_SYNC_SECOND,
		FAULT_LENGTH,
		FAULT_CHECKSUM,
		FAULT_END
	} fault_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  command;
		logic [15:0] height;
		motion_t     motion;
		logic        changed;
		logic        warning;
	} frame_result_t;

	logic clk;
	logic arst_n;

	dhfp_rx_if rx();
	dhfp_res_if res();

	desk_height_frame_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx.sink),
		.res    (res.source)
	);

	// parser state as predicted
	int            hunt_pos;
	int            end_pos;
	logic [7:0]    csum;
	logic [7:0]    cmd_latch;
	logic [15:0]   hbytes;
	logic [15:0]   prev_height;
	logic          prev_known;
	motion_t       prev_motion;
	logic          link_warning;

	frame_result_t pending_results[$];
	frame_result_t want;

	int src_idle_pct;
	int sink_idle_pct;
	int hold_request;
	int hold_left;
	int bytes_sent;
	int mismatches;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp_val));
	endtask

	task automatic queue_error(input kind_t kind);
		frame_result_t r;
		r = '0;
		r.kind = kind;
		r.motion = MOTION_IDLE;
		r.warning = 1'b1;
		link_warning = 1'b1;
		hunt_pos = 0;
		end_pos = FRAME_SPAN;
		pending_results.push_back(r);
	endtask

	task automatic predict_byte(input logic [7:0] b);
		frame_result_t r;
		motion_t       m;
		int            pos;
		pos = hunt_pos;
		if (pos >= FRAME_SPAN) begin
			hunt_pos = 0;
			end_pos = FRAME_SPAN;
			return;
		end
		if (pos == 4)
			hbytes[15:8] = b;
		else if (pos == 5)
			hbytes[7:0] = b;
		if (pos == 0 || pos == 1) begin
			if (b != SYNC_BYTE) begin
				queue_error(KIND_SYNC);
				return;
			end
		end else if (pos == 2) begin
			cmd_latch = b;
			csum = b;
		end else if (pos == 3) begin
			// no wrap: an end past the buffer is flagged
			if (int'(b) + int'(LEN_EXTRA) > FRAME_SPAN - 1) begin
				queue_error(KIND_LENGTH);
				return;
			end
			end_pos = int'(b) + int'(LEN_EXTRA);
			csum = csum + b;
		end else if (pos + 1 == end_pos) begin
			if (b != csum) begin
				queue_error(KIND_CHECKSUM);
				return;
			end
		end else if (pos == end_pos) begin
			if (b != END_BYTE) begin
				queue_error(KIND_END);
				return;
			end
			r = '0;
			r.kind = KIND_OTHER;
			r.command = cmd_latch;
			r.motion = MOTION_IDLE;
			link_warning = 1'b0;
			if (cmd_latch == HEIGHT_CMD) begin
				m = MOTION_IDLE;
				if (prev_known && hbytes > prev_height)
					m = MOTION_UP;
				else if (prev_known && hbytes < prev_height)
					m = MOTION_DOWN;
				r.kind = KIND_HEIGHT;
				r.height = hbytes;
				r.motion = m;
				r.changed = (m != prev_motion);
				prev_motion = m;
				prev_height = hbytes;
				prev_known = 1'b1;
			end
			hunt_pos = 0;
			end_pos = FRAME_SPAN;
			pending_results.push_back(r);
			return;
		end else begin
			csum = csum + b;
		end
		hunt_pos = pos + 1;
	endtask

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx.ready);
		predict_byte(b);
		bytes_sent++;
	endtask

	function automatic logic [7:0] other_than(input logic [7:0] avoid);
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == avoid);
		return v;
	endfunction

	// payload starts with the height, big-endian, when the length allows
	task automatic send_frame(input logic [7:0] cmd, input int len,
			input logic [15:0] height, input fault_t fault);
		logic [7:0] bytes[$];
		logic [7:0] sum;
		logic [7:0] p;
		if (fault == FAULT_SYNC_FIRST) begin
			bytes.push_back(other_than(SYNC_BYTE));
		end else if (fault == FAULT_SYNC_SECOND) begin
			bytes.push_back(SYNC_BYTE);
			bytes.push_back(other_than(SYNC_BYTE));
		end else begin
			bytes.push_back(SYNC_BYTE);
			bytes.push_back(SYNC_BYTE);
			bytes.push_back(cmd);
			bytes.push_back(8'(len));
			if (fault != FAULT_LENGTH) begin
				sum = cmd + 8'(len);
				for (int i = 0; i < len; i++) begin
					if (i == 0)
						p = height[15:8];
					else if (i == 1)
						p = height[7:0];
					else
						p = 8'($urandom_range(0, 255));
					sum = sum + p;
					bytes.push_back(p);
				end
				if (fault == FAULT_CHECKSUM) begin
					bytes.push_back(sum ^ 8'($urandom_range(1, 255)));
				end else begin
					bytes.push_back(sum);
					bytes.push_back(fault == FAULT_END ? other_than(END_BYTE) : END_BYTE);
				end
			end
		end
		foreach (bytes[i])
			send_byte(bytes[i]);
	endtask

	task automatic set_idling(input int src_pct, input int sink_pct);
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
	endtask

	task automatic test_directed_frames();
		send_frame(HEIGHT_CMD, 2, 16'h1234, FAULT_NONE);
		send_frame(HEIGHT_CMD, 2, 16'h1234, FAULT_NONE);
		send_frame(HEIGHT_CMD, 2, 16'hFFFF, FAULT_NONE);
		send_frame(HEIGHT_CMD, 3, 16'hFFFF, FAULT_NONE);
		send_frame(HEIGHT_CMD, 2, 16'h0000, FAULT_NONE);
		send_frame(HEIGHT_CMD, 2, 16'h0000, FAULT_NONE);
		send_frame(8'h00, 0, 16'h0000, FAULT_NONE);
		send_frame(8'hFF, MAX_LEN, 16'hA55A, FAULT_NONE);
		// short payload: height picks up checksum and end byte
		send_frame(HEIGHT_CMD, 0, 16'h0000, FAULT_NONE);
		send_frame(HEIGHT_CMD, 1, 16'h8000, FAULT_NONE);
		send_frame(HEIGHT_CMD, MAX_LEN, 16'h00FF, FAULT_NONE);
		send_frame(HEIGHT_CMD, 2, 16'h1111, FAULT_SYNC_FIRST);
		send_frame(HEIGHT_CMD, 2, 16'h1111, FAULT_SYNC_SECOND);
		send_frame(HEIGHT_CMD, MAX_LEN + 1, 16'h1111, FAULT_LENGTH);
		send_frame(HEIGHT_CMD, 255, 16'h1111, FAULT_LENGTH);
		send_frame(HEIGHT_CMD, 2, 16'h2222, FAULT_CHECKSUM);
		send_frame(HEIGHT_CMD, 2, 16'h3333, FAULT_END);
		send_frame(8'h42, 4, 16'h5A5A, FAULT_NONE);
	endtask

	task automatic test_random_frames(input int byte_budget);
		int          start;
		int          roll;
		int          len;
		logic [7:0]  cmd;
		logic [15:0] h;
		fault_t      fault;
		start = bytes_sent;
		while (bytes_sent - start < byte_budget) begin
			roll = $urandom_range(99);
			if (roll < 5) begin
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				cmd = (roll < 60) ? HEIGHT_CMD : 8'($urandom_range(0, 255));
				len = ($urandom_range(3) == 0) ? $urandom_range(0, MAX_LEN) : $urandom_range(2, 4);
				case ($urandom_range(7))
					0, 1: h = prev_height;
					2: h = prev_height + 16'($urandom_range(1, 20));
					3: h = prev_height - 16'($urandom_range(1, 20));
					4: h = 16'h0000;
					5: h = 16'hFFFF;
					default: h = 16'($urandom_range(0, 65535));
				endcase
				roll = $urandom_range(99);
				if (roll < 80)
					fault = FAULT_NONE;
				else if (roll < 84)
					fault = FAULT_SYNC_FIRST;
				else if (roll < 88)
					fault = FAULT_SYNC_SECOND;
				else if (roll < 92)
					fault = FAULT_LENGTH;
				else if (roll < 96)
					fault = FAULT_CHECKSUM;
				else
					fault = FAULT_END;
				if (fault == FAULT_LENGTH)
					len = $urandom_range(MAX_LEN + 1, 255);
				send_frame(cmd, len, h, fault);
			end
		end
	endtask

	// results pile up while the receiver holds off, so the input stalls
	task automatic test_backpressure();
		hold_request = HOLD_CYCLES;
		repeat (25)
			send_frame(8'($urandom_range(0, 255)), 0, 16'h0000, FAULT_NONE);
	endtask

	initial begin
		arst_n <= 1'b0;
		rx.valid <= 1'b0;
		rx.rx_byte <= '0;
		hunt_pos = 0;
		end_pos = FRAME_SPAN;
		csum = '0;
		cmd_latch = '0;
		hbytes = '0;
		prev_height = '0;
		prev_known = 1'b0;
		prev_motion = MOTION_IDLE;
		link_warning = 1'b0;
		hold_request = 0;
		bytes_sent = 0;
		mismatches = 0;
		set_idling(24, 79);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_random_frames(430);
		set_idling(79, 24);
		test_random_frames(430);
		set_idling(0, 0);
		test_random_frames(400);
		test_backpressure();

		rx.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// receiver: random ready, with a long hold-off counted here
	initial begin
		res.ready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				res.ready <= 1'b0;
				hold_left--;
			end else begin
				res.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result kind %0d with none pending", res.kind));
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 16'(res.kind), 16'(want.kind));
				check_field("command", 16'(res.command), 16'(want.command));
				check_field("height_tenths", res.height_tenths, want.height);
				check_field("motion", 16'(res.motion), 16'(want.motion));
				check_field("motion_changed", 16'(res.motion_changed), 16'(want.changed));
				check_field("warning", 16'(res.warning), 16'(want.warning));
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((rx.valid && rx.ready) || (res.valid && res.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial quiet_cycles = 0;

endmodule
